// File: sv/scrolling_terrain_map_macros.svh
// Assertion macros for the scrolling terrain map.
// Used by scrolling_terrain_map.sv; expects clk and rst in scope.
`ifndef SCROLLING_TERRAIN_MAP_MACROS_SVH
`define SCROLLING_TERRAIN_MAP_MACROS_SVH
`ifndef SYNTH
`define STM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("terrain map assertion failed");
`define STM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("terrain map assertion failed");
`else
`define STM_ASSERT(label, prop)
`define STM_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: sv/stm_pkg.sv
// Types and constants for the scrolling terrain map.
// No dependencies.
package stm_pkg;
  localparam int MAP_W = 128;
  localparam int MAP_H = 128;
  localparam int COL_W = $clog2(MAP_W);
  localparam int ROW_W = $clog2(MAP_H);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int HALF_W = MAP_W / 2;
  localparam int HALF_H = MAP_H / 2;

  localparam logic signed [15:0] UNKNOWN_HEIGHT = -16'sd25600;
  localparam logic signed [15:0] LOW_LIMIT = -16'sd24320;
  localparam logic signed [15:0] MIN_HEIGHT_RST = -16'sd768;

  localparam logic [1:0] ACT_HEIGHT = 2'd0;
  localparam logic [1:0] ACT_TYPE = 2'd1;
  localparam logic [1:0] ACT_FEATURE = 2'd2;
  localparam logic [1:0] ACT_READ = 2'd3;

  localparam logic [2:0] DIR_NONE = 3'd0;
  localparam logic [2:0] DIR_RIGHT = 3'd1;
  localparam logic [2:0] DIR_LEFT = 3'd2;
  localparam logic [2:0] DIR_UP = 3'd3;
  localparam logic [2:0] DIR_DOWN = 3'd4;

  localparam logic [1:0] REG_MIN_HEIGHT = 2'd0;
  localparam logic [1:0] REG_UNSCANNED = 2'd1;
  localparam logic [1:0] REG_UNKNOWN_FEAT = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic signed [15:0] write_value;
  } item_t;

  typedef struct packed {
    logic signed [15:0] cell_height;
    logic [3:0] cell_type;
    logic [3:0] cell_feature;
    logic [2:0] scroll_dir;
    logic write_dropped;
  } result_t;

  typedef struct packed {
    logic signed [15:0] height;
    logic [3:0] ctype;
    logic [3:0] feature;
  } cell_t;
endpackage

// File: sv/scrolling_terrain_map.sv
// Scrolling terrain map: one cell memory and a sequencer for accesses and scroll sweeps.
// Depends on stm_pkg and scrolling_terrain_map_macros.svh.
// Result: a dropped write, a scroll or an outside read is answered from S_IDLE itself; an
// in-window read or write passes through S_RD, a blended height through S_RD and S_BLEND.
// A new item is taken only in S_IDLE; a scroll holds busy for a sweep over every cell.
// Reset: a clearing pass over every cell with busy high; results cannot stall.
`include "scrolling_terrain_map_macros.svh"
module scrolling_terrain_map import stm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  item_t item,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output logic result_valid,
  output result_t result
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD = 3'd1;
  localparam logic [2:0] S_BLEND = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;

  localparam logic [2:0] MODE_CLEAR = 3'd0;

  logic [2:0] state, state_next;
  logic signed [15:0] min_height;
  logic [3:0] unscanned_code, unknown_feature_code;
  logic [31:0] ref_x, ref_y;

  cell_t mem [MAP_W*MAP_H];
  cell_t rdata, wdata;
  logic [ADDR_W-1:0] raddr, waddr;
  logic we;

  item_t cur;
  logic [ADDR_W-1:0] cur_addr;
  logic signed [20:0] sum;

  logic [2:0] sw_mode;
  logic [ADDR_W-1:0] cnt;
  logic last;
  logic p_vld, p_ok;
  logic [ADDR_W-1:0] p_addr;

  logic signed [31:0] rx, ry;
  logic in_win, low_drop;
  logic [ADDR_W-1:0] item_addr;
  logic [ROW_W-1:0] d_row;
  logic [COL_W-1:0] d_col;
  logic [ADDR_W-1:0] dest, src;
  logic src_ok;
  logic [19:0] ofs;
  logic [39:0] prod;
  logic [19:0] quot;
  cell_t unknown_cell;

  assign busy = (state != S_IDLE);
  // hold configuration off while anything is in flight
  assign cfg_ready = !busy;
  assign unknown_cell = '{height: UNKNOWN_HEIGHT, ctype: unscanned_code,
                          feature: unknown_feature_code};

  // Window check and cell address of the incoming item
  always_comb begin
    rx = item.cell_x - $signed(ref_x);
    ry = item.cell_y - $signed(ref_y);
    in_win = (rx < HALF_W) && (rx > -HALF_W) && (ry < HALF_H) && (ry > -HALF_H);
    low_drop = (item.action == ACT_HEIGHT) && (item.write_value < LOW_LIMIT);
    item_addr = {ROW_W'(HALF_H) - ry[ROW_W-1:0], COL_W'(HALF_W) - rx[COL_W-1:0]};
  end

  // Sweep source: each cell takes the one half a map further along, where that lies in the window
  always_comb begin
    dest = (sw_mode == DIR_RIGHT || sw_mode == DIR_UP) ? ~cnt : cnt;
    d_row = dest[ADDR_W-1:COL_W];
    d_col = dest[COL_W-1:0];
    src = dest;
    src_ok = 1'b0;
    case (sw_mode)
      DIR_RIGHT: begin
        src_ok = d_col > COL_W'(HALF_W);
        src = {d_row, d_col - COL_W'(HALF_W)};
      end
      DIR_LEFT: begin
        src_ok = d_col < COL_W'(HALF_W);
        src = {d_row, d_col + COL_W'(HALF_W)};
      end
      DIR_UP: begin
        src_ok = d_row > ROW_W'(HALF_H);
        src = {d_row - ROW_W'(HALF_H), d_col};
      end
      DIR_DOWN: begin
        src_ok = d_row < ROW_W'(HALF_H);
        src = {d_row + ROW_W'(HALF_H), d_col};
      end
      default: begin
        src_ok = 1'b0;
        src = dest;
      end
    endcase
  end

  // floor(sum/10) through an offset and a reciprocal multiply
  always_comb begin
    ofs = 20'(sum + 21'sd327680);
    prod = 40'(ofs) * 40'd838861;
    quot = 20'(prod[39:23]);
  end

  always_comb begin
    if (state == S_SWEEP) raddr = src;
    else if (state == S_RD) raddr = cur_addr;
    else raddr = item_addr;
    we = 1'b0;
    waddr = cur_addr;
    wdata = rdata;
    if (state == S_SWEEP) begin
      we = p_vld;
      waddr = p_addr;
      wdata = p_ok ? rdata : unknown_cell;
    end else if (state == S_RD) begin
      case (cur.action)
        ACT_HEIGHT: begin
          we = rdata.height < min_height;
          wdata.height = cur.write_value;
        end
        ACT_TYPE: begin
          we = 1'b1;
          wdata.ctype = cur.write_value[3:0];
        end
        ACT_FEATURE: begin
          we = 1'b1;
          wdata.feature = cur.write_value[3:0];
        end
        default: we = 1'b0;
      endcase
    end else if (state == S_BLEND) begin
      we = 1'b1;
      wdata.height = 16'(quot - 20'd32768);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:
        if (start) begin
          if (item.action == ACT_READ) state_next = in_win ? S_RD : S_IDLE;
          else if (low_drop) state_next = S_IDLE;
          else state_next = in_win ? S_RD : S_SWEEP;
        end
      S_RD:
        state_next = (cur.action == ACT_HEIGHT && rdata.height >= min_height) ?
                     S_BLEND : S_IDLE;
      S_BLEND: state_next = S_IDLE;
      S_SWEEP: if (last && !p_vld) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      sw_mode <= MODE_CLEAR;
      cnt <= '0;
      last <= 1'b0;
      p_vld <= 1'b0;
      result_valid <= 1'b0;
      ref_x <= '0;
      ref_y <= '0;
      min_height <= MIN_HEIGHT_RST;
      unscanned_code <= '0;
      unknown_feature_code <= '0;
    end else begin
      state <= state_next;
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_HEIGHT: min_height <= cfg_data;
          REG_UNSCANNED: unscanned_code <= cfg_data[3:0];
          REG_UNKNOWN_FEAT: unknown_feature_code <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (state == S_SWEEP) begin
        p_vld <= !last;
        p_addr <= dest;
        p_ok <= src_ok;
        if (!last) begin
          cnt <= cnt + 1'b1;
          if (&cnt) last <= 1'b1;
        end
      end
      case (state)
        S_IDLE:
          if (start) begin
            cur <= item;
            cur_addr <= item_addr;
            if (item.action == ACT_READ) begin
              if (!in_win) begin
                result <= '{UNKNOWN_HEIGHT, unscanned_code, unknown_feature_code,
                            DIR_NONE, 1'b0};
                result_valid <= 1'b1;
              end
            end else if (low_drop) begin
              result <= '{16'sd0, 4'd0, 4'd0, DIR_NONE, 1'b1};
              result_valid <= 1'b1;
            end else if (!in_win) begin
              // scroll instead of writing, x before y
              result_valid <= 1'b1;
              cnt <= '0;
              last <= 1'b0;
              if (rx >= HALF_W) begin
                sw_mode <= DIR_RIGHT;
                result <= '{16'sd0, 4'd0, 4'd0, DIR_RIGHT, 1'b1};
                ref_x <= ref_x + 32'(HALF_W);
              end else if (rx <= -HALF_W) begin
                sw_mode <= DIR_LEFT;
                result <= '{16'sd0, 4'd0, 4'd0, DIR_LEFT, 1'b1};
                ref_x <= ref_x - 32'(HALF_W);
              end else if (ry >= HALF_H) begin
                sw_mode <= DIR_UP;
                result <= '{16'sd0, 4'd0, 4'd0, DIR_UP, 1'b1};
                ref_y <= ref_y + 32'(HALF_H);
              end else begin
                sw_mode <= DIR_DOWN;
                result <= '{16'sd0, 4'd0, 4'd0, DIR_DOWN, 1'b1};
                ref_y <= ref_y - 32'(HALF_H);
              end
            end
          end
        S_RD: begin
          sum <= 21'(rdata.height) * 21'sd9 + 21'(cur.write_value);
          if (state_next == S_IDLE) begin
            result_valid <= 1'b1;
            if (cur.action == ACT_READ) begin
              result <= '{rdata.height, rdata.ctype, rdata.feature, DIR_NONE, 1'b0};
            end else begin
              result <= '0;
            end
          end
        end
        S_BLEND: begin
          result <= '0;
          result_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  `STM_ASSERT(a_idle_no_sweep_write, (state == S_IDLE) |-> !p_vld)
  `STM_ASSERT(a_blend_after_read, (state == S_BLEND) |-> ($past(state) == S_RD))
  `STM_ASSERT(a_scroll_drops, (result_valid && |result.scroll_dir) |-> result.write_dropped)
  `STM_ASSERT(a_no_cfg_when_busy, busy |-> !cfg_ready)
endmodule

// File: dv/scrolling_terrain_map_tb.sv
// Self-checking testbench for the scrolling terrain map: directed and random transactions
// checked against an in-bench model of the map store, scrolling and blending.
// Depends on stm_pkg and the scrolling_terrain_map RTL.
module scrolling_terrain_map_tb import stm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = MAP_W * MAP_H;
  localparam int CYCLE_LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic result_valid;
  result_t result;

  scrolling_terrain_map dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
  );

  always #5 clk = ~clk;

  // map state mirrored by the bench
  logic signed [15:0] map_height[CELLS];
  logic [3:0] map_type[CELLS];
  logic [3:0] map_feature[CELLS];
  logic signed [15:0] old_height[CELLS];
  logic [3:0] old_type[CELLS];
  logic [3:0] old_feature[CELLS];
  logic [31:0] origin_x = '0;
  logic [31:0] origin_y = '0;
  logic signed [15:0] min_height = MIN_HEIGHT_RST;
  logic [3:0] unscanned_code = '0;
  logic [3:0] unknown_feature_code = '0;

  result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 0;

  function automatic bit in_window(int rx, int ry);
    return rx < HALF_W && rx > -HALF_W && ry < HALF_H && ry > -HALF_H;
  endfunction

  function automatic int cell_addr(int rx, int ry);
    return (HALF_H - ry) * MAP_W + (HALF_W - rx);
  endfunction

  task automatic shift_map(int dx, int dy);
    int d, s;
    old_height = map_height;
    old_type = map_type;
    old_feature = map_feature;
    origin_x = origin_x + dx;
    origin_y = origin_y + dy;
    for (int ry = -HALF_H + 1; ry < HALF_H; ry++) begin
      for (int rx = -HALF_W + 1; rx < HALF_W; rx++) begin
        d = cell_addr(rx, ry);
        if (in_window(rx + dx, ry + dy)) begin
          s = cell_addr(rx + dx, ry + dy);
          map_height[d] = old_height[s];
          map_type[d] = old_type[s];
          map_feature[d] = old_feature[s];
        end else begin
          map_height[d] = UNKNOWN_HEIGHT;
          map_type[d] = unscanned_code;
          map_feature[d] = unknown_feature_code;
        end
      end
    end
  endtask

  task automatic predict_map(input item_t it, output result_t r);
    int rx, ry, a, sum, q, prev;
    logic signed [31:0] drx, dry;
    drx = it.cell_x - origin_x;
    dry = it.cell_y - origin_y;
    rx = drx;
    ry = dry;
    r = '0;
    if (it.action == ACT_READ) begin
      if (in_window(rx, ry)) begin
        a = cell_addr(rx, ry);
        r.cell_height = map_height[a];
        r.cell_type = map_type[a];
        r.cell_feature = map_feature[a];
      end else begin
        r.cell_height = UNKNOWN_HEIGHT;
        r.cell_type = unscanned_code;
        r.cell_feature = unknown_feature_code;
      end
    end else if (it.action == ACT_HEIGHT && it.write_value < LOW_LIMIT) begin
      r.write_dropped = 1'b1;
    end else if (rx >= HALF_W) begin
      shift_map(HALF_W, 0); r.scroll_dir = DIR_RIGHT; r.write_dropped = 1'b1;
    end else if (rx <= -HALF_W) begin
      shift_map(-HALF_W, 0); r.scroll_dir = DIR_LEFT; r.write_dropped = 1'b1;
    end else if (ry >= HALF_H) begin
      shift_map(0, HALF_H); r.scroll_dir = DIR_UP; r.write_dropped = 1'b1;
    end else if (ry <= -HALF_H) begin
      shift_map(0, -HALF_H); r.scroll_dir = DIR_DOWN; r.write_dropped = 1'b1;
    end else begin
      a = cell_addr(rx, ry);
      if (it.action == ACT_HEIGHT) begin
        prev = map_height[a];
        if (map_height[a] < min_height) begin
          map_height[a] = it.write_value;
        end else begin
          sum = 9 * prev + int'(it.write_value);
          q = sum / 10;
          if (sum % 10 != 0 && sum < 0) q--;
          map_height[a] = q[15:0];
        end
      end else if (it.action == ACT_TYPE) begin
        map_type[a] = it.write_value[3:0];
      end else begin
        map_feature[a] = it.write_value[3:0];
      end
    end
  endtask

  // relative coordinates to an absolute transaction, against the current origin
  function automatic item_t at_cell(logic [1:0] act, int rx, int ry, logic [15:0] v);
    item_t it;
    it.action = act;
    it.cell_x = origin_x + rx;
    it.cell_y = origin_y + ry;
    it.write_value = v;
    return it;
  endfunction

  // called at a falling edge; leaves start high if the next transaction follows at once
  task automatic send_item(input item_t it);
    result_t r;
    int gap;
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    predict_map(it, r);
    pending_results.insert(pending_results.size(), r);
    @(negedge clk);
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // hold through any scroll sweep still in progress
    do @(negedge clk); while (busy);
    repeat (4) @(negedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_HEIGHT: min_height = val;
      REG_UNSCANNED: unscanned_code = val[3:0];
      REG_UNKNOWN_FEAT: unknown_feature_code = val[3:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(logic [15:0] mh, logic [3:0] uc, logic [3:0] uf);
    drain();
    write_reg(REG_MIN_HEIGHT, mh);
    write_reg(REG_UNSCANNED, {12'h0, uc});
    write_reg(REG_UNKNOWN_FEAT, {12'h0, uf});
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_directed;
    send_item(at_cell(ACT_READ, 0, 0, 16'h0));
    send_item('{ACT_READ, 32'sh7fffffff, 32'sh80000000, 16'shffff});
    // heights at and below the low limit
    send_item(at_cell(ACT_HEIGHT, 0, 0, UNKNOWN_HEIGHT));
    send_item('{ACT_HEIGHT, 32'sh7fffffff, 32'sh7fffffff, -16'sd24321});
    send_item(at_cell(ACT_HEIGHT, 0, 0, LOW_LIMIT));
    send_item(at_cell(ACT_HEIGHT, 0, 0, 16'sh7fff));
    send_item(at_cell(ACT_HEIGHT, 0, 0, 16'sh7fff));
    send_item(at_cell(ACT_HEIGHT, 0, 0, LOW_LIMIT));
    // negative blend rounds toward minus infinity
    send_item(at_cell(ACT_HEIGHT, 1, 1, -16'sd768));
    send_item(at_cell(ACT_HEIGHT, 1, 1, -16'sd769));
    send_item(at_cell(ACT_READ, 1, 1, 16'h0));
    send_item(at_cell(ACT_TYPE, 63, -63, 16'hffff));
    send_item(at_cell(ACT_FEATURE, -63, 63, 16'h5a5a));
    send_item(at_cell(ACT_READ, 63, -63, 16'h0));
    send_item(at_cell(ACT_READ, -63, 63, 16'h0));
    send_item(at_cell(ACT_READ, 0, 0, 16'h0));
    // window edges: every scroll direction, x before y
    send_item(at_cell(ACT_TYPE, 64, 64, 16'h0003));
    send_item(at_cell(ACT_READ, -1, -63, 16'h0));
    send_item(at_cell(ACT_FEATURE, -64, 0, 16'h0007));
    send_item(at_cell(ACT_HEIGHT, 0, 64, 16'sh0100));
    send_item(at_cell(ACT_HEIGHT, 0, -64, 16'sh0100));
    send_item('{ACT_TYPE, 32'sh80000000, 32'sh0, 16'h0001});
    send_item(at_cell(ACT_READ, 63, 63, 16'h0));
    send_item(at_cell(ACT_READ, -63, -63, 16'h0));
  endtask

  function automatic int rand_rel;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return $urandom_range(0, 6) - 3;
    return $urandom_range(0, 126) - 63;
  endfunction

  function automatic item_t rand_item;
    item_t it;
    int sel;
    logic [15:0] v;
    sel = $urandom_range(0, 999);
    v = 16'($urandom());
    if ($urandom_range(0, 3) != 0) v = 16'($urandom_range(0, 57087) - 24320);
    it = at_cell(2'($urandom_range(0, 3)), rand_rel(), rand_rel(), v);
    if (sel < 60) begin
      // out-of-window or wild coordinates, read only
      it.action = ACT_READ;
      it.cell_x = $urandom();
      it.cell_y = $urandom();
    end else if (sel < 70) begin
      it.action = 2'($urandom_range(0, 2));
      it.write_value = $urandom_range(0, 1) ? 16'sh8000 : -16'sd24321;
      it.cell_x = $urandom();
    end else if (sel < 80 && it.action != ACT_READ) begin
      // write past the edge: scroll
      if ($urandom_range(0, 1)) it.cell_x = origin_x + ($urandom_range(0, 1) ? 64 : -64);
      else it.cell_y = origin_y + ($urandom_range(0, 1) ? 64 + $urandom_range(0, 9) : -64);
      if (it.action == ACT_HEIGHT) it.write_value = 16'sh0200;
    end
    return it;
  endfunction

  task automatic test_random(int n, bit pause_mid);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (pause_mid && i == n / 2) begin
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      send_item(rand_item());
    end
  endtask

  task automatic test_config_extremes;
    set_config(-16'sd25600, 4'hf, 4'hf);
    send_item(at_cell(ACT_READ, 0, 0, 16'h0));
    send_item('{ACT_READ, 32'sh40000000, 32'sh0, 16'h0});
    send_item(at_cell(ACT_HEIGHT, 2, 2, -16'sd24000));
    send_item(at_cell(ACT_HEIGHT, 2, 2, 16'sh7fff));
    send_item(at_cell(ACT_TYPE, 70, 0, 16'h0));
    send_item(at_cell(ACT_READ, -63, 0, 16'h0));
    test_random(300, 1'b1);
    set_config(16'sh7fff, 4'h0, 4'h0);
    send_item(at_cell(ACT_HEIGHT, 2, 2, -16'sd100));
    send_item(at_cell(ACT_FEATURE, 0, -70, 16'h0));
    test_random(300, 1'b0);
  endtask

  task automatic test_config_random;
    repeat (2) begin
      set_config(16'($urandom_range(0, 58367) - 25600), 4'($urandom()), 4'($urandom()));
      test_random(150, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding: %p", result);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result.cell_height !== want.cell_height) begin
          $error("cell_height expected %0d got %0d", want.cell_height, result.cell_height);
          errors++;
        end
        if (result.cell_type !== want.cell_type) begin
          $error("cell_type expected %0d got %0d", want.cell_type, result.cell_type);
          errors++;
        end
        if (result.cell_feature !== want.cell_feature) begin
          $error("cell_feature expected %0d got %0d", want.cell_feature, result.cell_feature);
          errors++;
        end
        if (result.scroll_dir !== want.scroll_dir) begin
          $error("scroll_dir expected %0d got %0d", want.scroll_dir, result.scroll_dir);
          errors++;
        end
        if (result.write_dropped !== want.write_dropped) begin
          $error("write_dropped expected %0d got %0d", want.write_dropped,
                 result.write_dropped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      map_height[i] = UNKNOWN_HEIGHT;
      map_type[i] = '0;
      map_feature[i] = '0;
    end
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(300, 1'b0);
    test_config_extremes();
    test_config_random();
    drain();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
